### hw/rtl/nmeatr_pkg.sv
// Shared types, constants and helpers for the NMEA talker-ID rewriter.
// No dependencies; every other file of the block refers to this package.
package nmeatr_pkg;

	localparam int unsigned MAX_BODY_BYTES = 511;
	localparam int unsigned CNT_W          = $clog2(MAX_BODY_BYTES + 1);
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned BYTE_W         = 8;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_MATCH_ANY  = 3'd1,
		REG_SRC_FIRST  = 3'd2,
		REG_SRC_SECOND = 3'd3,
		REG_DST_FIRST  = 3'd4,
		REG_DST_SECOND = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DOLLAR = 3'd1,
		PH_FIRST  = 3'd2,
		PH_BODY   = 3'd3,
		PH_STAR   = 3'd4,
		PH_DIGIT1 = 3'd5
	} phase_t;

	typedef struct packed {
		logic              enable;
		logic              match_any;
		logic [BYTE_W-1:0] src_first;
		logic [BYTE_W-1:0] src_second;
		logic [BYTE_W-1:0] dst_first;
		logic [BYTE_W-1:0] dst_second;
	} cfg_t;

	// uppercase hex character for one nibble
	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
		logic [BYTE_W-1:0] wide;
		begin
			wide = {4'h0, nib};
			hex_digit = (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
		end
	endfunction

endpackage

### hw/rtl/nmeatr_in_if.sv
// Input stream channel: one received byte per word, valid/ready handshake.
// Depends on nmeatr_pkg for the byte width.
interface nmeatr_in_if;
	logic                            valid;
	logic                            ready;
	logic [nmeatr_pkg::BYTE_W-1:0]   in_byte;
	logic                            end_of_read;

	modport source (output valid, output in_byte, output end_of_read, input ready);
	modport sink   (input valid, input in_byte, input end_of_read, output ready);
endinterface

### hw/rtl/nmeatr_out_if.sv
// Output stream channel: one passed or rewritten byte per word.
// Depends on nmeatr_pkg for the byte width.
interface nmeatr_out_if;
	logic                            valid;
	logic                            ready;
	logic [nmeatr_pkg::BYTE_W-1:0]   out_byte;
	logic                            was_rewritten;
	logic                            end_of_read_out;

	modport source (output valid, output out_byte, output was_rewritten,
		output end_of_read_out, input ready);
	modport sink   (input valid, input out_byte, input was_rewritten,
		input end_of_read_out, output ready);
endinterface

### hw/rtl/nmeatr_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on nmeatr_pkg for index and data widths.
interface nmeatr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [nmeatr_pkg::CFG_IDX_W-1:0]   addr;
	logic [nmeatr_pkg::BYTE_W-1:0]      data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

### hw/rtl/nmeatr_cfg_regs.sv
// Configuration register file of the talker-ID rewriter.
// Depends on nmeatr_pkg and nmeatr_cfg_if.
module nmeatr_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	nmeatr_cfg_if.sink           cfg,
	output nmeatr_pkg::cfg_t     regs
);

	nmeatr_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enable     <= 1'b0;
			regs_q.match_any  <= 1'b1;
			regs_q.src_first  <= 8'h47;
			regs_q.src_second <= 8'h50;
			regs_q.dst_first  <= 8'h47;
			regs_q.dst_second <= 8'h50;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				nmeatr_pkg::REG_ENABLE:     regs_q.enable     <= cfg.data[0];
				nmeatr_pkg::REG_MATCH_ANY:  regs_q.match_any  <= cfg.data[0];
				nmeatr_pkg::REG_SRC_FIRST:  regs_q.src_first  <= cfg.data;
				nmeatr_pkg::REG_SRC_SECOND: regs_q.src_second <= cfg.data;
				nmeatr_pkg::REG_DST_FIRST:  regs_q.dst_first  <= cfg.data;
				nmeatr_pkg::REG_DST_SECOND: regs_q.dst_second <= cfg.data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

### hw/rtl/nmeatr_xlate.sv
// Sentence tracker: phase, running XOR and body count, plus byte substitution.
// Depends on nmeatr_pkg. State advances only when step is high.
module nmeatr_xlate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nmeatr_pkg::cfg_t                  regs,
	input  logic                              step,
	input  logic [nmeatr_pkg::BYTE_W-1:0]     in_byte,
	output logic [nmeatr_pkg::BYTE_W-1:0]     out_byte,
	output logic                              was_rewritten
);

	localparam int unsigned CW = nmeatr_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_LIMIT = CW'(nmeatr_pkg::MAX_BODY_BYTES);

	nmeatr_pkg::phase_t phase_q, phase_d;
	logic [nmeatr_pkg::BYTE_W-1:0] xor_q, xor_d, xor_w;
	logic [CW-1:0] cnt_q, cnt_d, cnt_w;
	logic active, first_ok, second_ok, pre_star;

	assign active    = regs.enable && (in_byte != nmeatr_pkg::CH_NUL);
	assign first_ok  = regs.match_any || (in_byte == regs.src_first);
	assign second_ok = regs.match_any || (in_byte == regs.src_second);
	assign pre_star  = (phase_q == nmeatr_pkg::PH_IDLE) || (phase_q == nmeatr_pkg::PH_DOLLAR)
		|| (phase_q == nmeatr_pkg::PH_FIRST) || (phase_q == nmeatr_pkg::PH_BODY);

	// next state
	always_comb begin
		xor_w   = xor_q;
		cnt_w   = cnt_q;
		// overlong body: count restarts, checksum too before the star
		if (cnt_q >= CNT_LIMIT) begin
			cnt_w = '0;
			if (pre_star) begin
				xor_w = '0;
			end
		end
		phase_d = phase_q;
		xor_d   = xor_w;
		cnt_d   = cnt_w;
		unique case (phase_q)
			nmeatr_pkg::PH_IDLE: begin
				if (in_byte == nmeatr_pkg::CH_DOLLAR) begin
					phase_d = nmeatr_pkg::PH_DOLLAR;
					xor_d   = '0;
					cnt_d   = '0;
				end
			end
			nmeatr_pkg::PH_DOLLAR: begin
				if (first_ok) begin
					phase_d = nmeatr_pkg::PH_FIRST;
					xor_d   = xor_w ^ regs.dst_first;
					cnt_d   = cnt_w + 1'b1;
				end else begin
					phase_d = nmeatr_pkg::PH_IDLE;
					cnt_d   = '0;
				end
			end
			nmeatr_pkg::PH_FIRST: begin
				if (second_ok) begin
					phase_d = nmeatr_pkg::PH_BODY;
					xor_d   = xor_w ^ regs.dst_second;
					cnt_d   = cnt_w + 1'b1;
				end else begin
					phase_d = nmeatr_pkg::PH_IDLE;
					cnt_d   = '0;
				end
			end
			nmeatr_pkg::PH_BODY: begin
				if (in_byte == nmeatr_pkg::CH_STAR) begin
					phase_d = nmeatr_pkg::PH_STAR;
				end else begin
					xor_d = xor_w ^ in_byte;
					cnt_d = cnt_w + 1'b1;
				end
			end
			nmeatr_pkg::PH_STAR: begin
				phase_d = nmeatr_pkg::PH_DIGIT1;
			end
			nmeatr_pkg::PH_DIGIT1: begin
				phase_d = nmeatr_pkg::PH_IDLE;
				cnt_d   = '0;
			end
			default: begin
				phase_d = nmeatr_pkg::PH_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// byte substitution
	always_comb begin
		out_byte      = in_byte;
		was_rewritten = 1'b0;
		if (active) begin
			unique case (phase_q)
				nmeatr_pkg::PH_DOLLAR: begin
					if (first_ok) begin
						out_byte      = regs.dst_first;
						was_rewritten = 1'b1;
					end
				end
				nmeatr_pkg::PH_FIRST: begin
					if (second_ok) begin
						out_byte      = regs.dst_second;
						was_rewritten = 1'b1;
					end
				end
				nmeatr_pkg::PH_STAR: begin
					out_byte      = nmeatr_pkg::hex_digit(xor_q[7:4]);
					was_rewritten = 1'b1;
				end
				nmeatr_pkg::PH_DIGIT1: begin
					out_byte      = nmeatr_pkg::hex_digit(xor_q[3:0]);
					was_rewritten = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nmeatr_pkg::PH_IDLE;
			xor_q   <= '0;
			cnt_q   <= '0;
		end else if (step && active) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### hw/rtl/nmea_talker_id_rewriter_core.sv
// NMEA 0183 talker-ID rewriter with checksum regeneration, two-stage pipeline.
// Depends on nmeatr_pkg, the three channel interfaces, nmeatr_cfg_regs and nmeatr_xlate.
//
// Usage:
//   item   - input stream, one byte (plus end-of-read flag) per word.
//   result - output stream, exactly one word per input word, in order.
//   cfg    - register writes (enable, match-any, source and destination
//            talker characters); always ready, write only while the stream
//            is drained.
// From input acceptance to result acceptance a word passes one input
// register, then the substitution and state update land in the result
// register. Throughput is one byte per cycle while the receiver does not
// stall, as the phase / XOR / count registers update at every step.
// A stalled receiver holds the result register; the input register keeps
// taking a word while the result register is being emptied in the same
// cycle, so item.ready follows result.ready through one stage.
// Reset clears both valid flags, returns the tracker to waiting for '$'
// and loads the default registers (disabled, match any, "GP" to "GP").
module nmea_talker_id_rewriter_core (
	input  logic            clk,
	input  logic            arst_n,
	nmeatr_in_if.sink       item,
	nmeatr_out_if.source    result,
	nmeatr_cfg_if.sink      cfg
);

	nmeatr_pkg::cfg_t regs;

	logic                              valid_s1;
	logic [nmeatr_pkg::BYTE_W-1:0]     byte_s1;
	logic                              eor_s1;
	logic                              valid_s2;
	logic [nmeatr_pkg::BYTE_W-1:0]     byte_s2;
	logic                              rw_s2;
	logic                              eor_s2;
	logic                              s2_free, step;
	logic [nmeatr_pkg::BYTE_W-1:0]     sub_byte;
	logic                              sub_rw;

	nmeatr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign s2_free    = !valid_s2 || result.ready;
	assign step       = valid_s1 && s2_free;
	assign item.ready = !valid_s1 || s2_free;

	nmeatr_xlate u_xlate (
		.clk           (clk),
		.arst_n        (arst_n),
		.regs          (regs),
		.step          (step),
		.in_byte       (byte_s1),
		.out_byte      (sub_byte),
		.was_rewritten (sub_rw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			byte_s1 <= item.in_byte;
			eor_s1  <= item.end_of_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byte_s2 <= sub_byte;
			rw_s2   <= sub_rw;
			eor_s2  <= eor_s1;
		end
	end

	assign result.valid           = valid_s2;
	assign result.out_byte        = byte_s2;
	assign result.was_rewritten   = rw_s2;
	assign result.end_of_read_out = eor_s2;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for nmea_talker_id_rewriter_core: drives NMEA byte streams and register writes,
// predicts every output word in a scoreboard class and compares them in order.
// Depends on nmeatr_pkg and the three channel interfaces.
module testbench;

	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		logic [nmeatr_pkg::BYTE_W-1:0] data;
		logic                          rewritten;
		logic                          eor;
	} byte_word_t;

	class talker_rewrite_model;
		nmeatr_pkg::cfg_t              regs;
		nmeatr_pkg::phase_t            phase;
		logic [nmeatr_pkg::BYTE_W-1:0] xor_acc;
		logic [nmeatr_pkg::CNT_W-1:0]  body_cnt;
		byte_word_t                    expected_bytes[$];
		int                            mismatches;

		function new();
			regs.enable     = 1'b0;
			regs.match_any  = 1'b1;
			regs.src_first  = 8'h47;
			regs.src_second = 8'h50;
			regs.dst_first  = 8'h47;
			regs.dst_second = 8'h50;
			phase           = nmeatr_pkg::PH_IDLE;
			xor_acc         = '0;
			body_cnt        = '0;
			mismatches      = 0;
		endfunction

		function void set_reg(nmeatr_pkg::reg_idx_t idx, logic [nmeatr_pkg::BYTE_W-1:0] val);
			case (idx)
				nmeatr_pkg::REG_ENABLE:     regs.enable     = val[0];
				nmeatr_pkg::REG_MATCH_ANY:  regs.match_any  = val[0];
				nmeatr_pkg::REG_SRC_FIRST:  regs.src_first  = val;
				nmeatr_pkg::REG_SRC_SECOND: regs.src_second = val;
				nmeatr_pkg::REG_DST_FIRST:  regs.dst_first  = val;
				nmeatr_pkg::REG_DST_SECOND: regs.dst_second = val;
				default: ;
			endcase
		endfunction

		function logic [nmeatr_pkg::BYTE_W-1:0] nibble_char(logic [3:0] nib);
			logic [nmeatr_pkg::BYTE_W-1:0] n8;
			n8 = {4'h0, nib};
			return (nib < 4'd10) ? (8'h30 + n8) : (8'h41 + n8 - 8'd10);
		endfunction

		function void note_input(logic [nmeatr_pkg::BYTE_W-1:0] c, logic eor);
			byte_word_t w;
			w.data      = c;
			w.rewritten = 1'b0;
			w.eor       = eor;
			if (regs.enable && c != nmeatr_pkg::CH_NUL) begin
				// length limit: count restarts, checksum too while still in the body
				if (body_cnt >= nmeatr_pkg::MAX_BODY_BYTES) begin
					body_cnt = '0;
					if (phase <= nmeatr_pkg::PH_BODY)
						xor_acc = '0;
				end
				case (phase)
					nmeatr_pkg::PH_IDLE: begin
						if (c == nmeatr_pkg::CH_DOLLAR) begin
							phase    = nmeatr_pkg::PH_DOLLAR;
							xor_acc  = '0;
							body_cnt = '0;
						end
					end
					nmeatr_pkg::PH_DOLLAR: begin
						if (regs.match_any || c == regs.src_first) begin
							w.data      = regs.dst_first;
							w.rewritten = 1'b1;
							xor_acc     = xor_acc ^ regs.dst_first;
							body_cnt    = body_cnt + 1'b1;
							phase       = nmeatr_pkg::PH_FIRST;
						end else begin
							phase    = nmeatr_pkg::PH_IDLE;
							body_cnt = '0;
						end
					end
					nmeatr_pkg::PH_FIRST: begin
						if (regs.match_any || c == regs.src_second) begin
							w.data      = regs.dst_second;
							w.rewritten = 1'b1;
							xor_acc     = xor_acc ^ regs.dst_second;
							body_cnt    = body_cnt + 1'b1;
							phase       = nmeatr_pkg::PH_BODY;
						end else begin
							phase    = nmeatr_pkg::PH_IDLE;
							body_cnt = '0;
						end
					end
					nmeatr_pkg::PH_BODY: begin
						if (c == nmeatr_pkg::CH_STAR) begin
							phase = nmeatr_pkg::PH_STAR;
						end else begin
							xor_acc  = xor_acc ^ c;
							body_cnt = body_cnt + 1'b1;
						end
					end
					nmeatr_pkg::PH_STAR: begin
						w.data      = nibble_char(xor_acc[7:4]);
						w.rewritten = 1'b1;
						phase       = nmeatr_pkg::PH_DIGIT1;
					end
					nmeatr_pkg::PH_DIGIT1: begin
						w.data      = nibble_char(xor_acc[3:0]);
						w.rewritten = 1'b1;
						phase       = nmeatr_pkg::PH_IDLE;
						body_cnt    = '0;
					end
					default: begin
						phase    = nmeatr_pkg::PH_IDLE;
						body_cnt = '0;
					end
				endcase
			end
			expected_bytes.push_back(w);
		endfunction

		function void check_output(logic [nmeatr_pkg::BYTE_W-1:0] data, logic rewritten,
			logic eor);
			byte_word_t w;
			if (expected_bytes.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected output word %02h rw %0d eor %0d, nothing pending",
						data, rewritten, eor);
				mismatches++;
				return;
			end
			w = expected_bytes.pop_front();
			if (data !== w.data || rewritten !== w.rewritten || eor !== w.eor) begin
				if (mismatches < 10)
					$display({"mismatch at %0t: expected %02h rw %0d eor %0d, ",
						"got %02h rw %0d eor %0d"},
						$realtime, w.data, w.rewritten, w.eor, data, rewritten, eor);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	nmeatr_in_if  in_ch();
	nmeatr_out_if out_ch();
	nmeatr_cfg_if cfg_ch();

	nmea_talker_id_rewriter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	talker_rewrite_model sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int sent           = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_reg(nmeatr_pkg::reg_idx_t'(cfg_ch.addr), cfg_ch.data);
			if (in_ch.valid && in_ch.ready)
				sb.note_input(in_ch.in_byte, in_ch.end_of_read);
			if (out_ch.valid && out_ch.ready)
				sb.check_output(out_ch.out_byte, out_ch.was_rewritten, out_ch.end_of_read_out);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_byte(input logic [nmeatr_pkg::BYTE_W-1:0] b, input logic eor);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.in_byte     <= b;
		in_ch.end_of_read <= eor;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic en, input logic any,
		input logic [nmeatr_pkg::BYTE_W-1:0] s1, input logic [nmeatr_pkg::BYTE_W-1:0] s2,
		input logic [nmeatr_pkg::BYTE_W-1:0] d1, input logic [nmeatr_pkg::BYTE_W-1:0] d2);
		logic [nmeatr_pkg::BYTE_W-1:0] vals[6];
		vals = '{{7'h0, en}, {7'h0, any}, s1, s2, d1, d2};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.addr  <= nmeatr_pkg::CFG_IDX_W'(i);
			cfg_ch.data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// '$', talker pair, body, '*', two checksum slots, optional CR LF
	task automatic send_sentence(input int body_len, input bit hit);
		logic [nmeatr_pkg::BYTE_W-1:0] b;
		send_byte(nmeatr_pkg::CH_DOLLAR, $urandom_range(7) == 0);
		b = hit ? sb.regs.src_first : 8'($urandom_range(255));
		send_byte(b, $urandom_range(7) == 0);
		b = hit ? sb.regs.src_second : 8'($urandom_range(255));
		send_byte(b, $urandom_range(7) == 0);
		for (int k = 0; k < body_len; k++) begin
			if (body_len <= 20 && $urandom_range(15) == 0) begin
				b = $urandom_range(1) ? nmeatr_pkg::CH_NUL : nmeatr_pkg::CH_DOLLAR;
			end else begin
				b = 8'($urandom_range(255, 1));
				if (b == nmeatr_pkg::CH_STAR)
					b = 8'h2B;
			end
			send_byte(b, $urandom_range(7) == 0);
		end
		send_byte(nmeatr_pkg::CH_STAR, $urandom_range(7) == 0);
		send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
		send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
		if ($urandom_range(1)) begin
			send_byte(8'h0D, 1'b0);
			send_byte(8'h0A, $urandom_range(3) == 0);
		end
	endtask

	initial begin
		logic [nmeatr_pkg::BYTE_W-1:0] dir_off[4];
		logic [nmeatr_pkg::BYTE_W-1:0] dir_on[14];
		int idle_tbl[4];
		int stall_tbl[4];
		int long_tbl[4];
		int goal;
		int pick;
		int n;
		bit paused;

		dir_off   = '{8'h24, 8'h47, 8'h50, 8'h2A};
		dir_on    = '{8'h00, 8'hFF, 8'h2A, 8'h24, 8'h47, 8'h00, 8'h50,
			8'h41, 8'hFF, 8'h24, 8'h2A, 8'h30, 8'h00, 8'h30};
		idle_tbl  = '{0, 46, 0, 27};
		stall_tbl = '{0, 0, 46, 27};
		long_tbl  = '{0, 0, 0, 512};

		arst_n             = 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.in_byte     <= '0;
		in_ch.end_of_read <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.addr       <= '0;
		cfg_ch.data       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: disabled, bytes pass through
		foreach (dir_off[i])
			send_byte(dir_off[i], i == 3);
		wait_drained();

		apply_settings(1'b1, 1'b1, 8'h47, 8'h50, 8'h47, 8'h4E);
		// zero bytes, stray star, '$' inside body, checksum slots
		foreach (dir_on[i])
			send_byte(dir_on[i], i == 13);
		// disable mid-sentence: state must hold across the gap
		send_byte(nmeatr_pkg::CH_DOLLAR, 1'b0);
		send_byte(8'h58, 1'b0);
		send_byte(8'h59, 1'b0);
		send_byte(8'h42, 1'b0);
		wait_drained();
		apply_settings(1'b0, 1'b1, 8'h47, 8'h50, 8'h47, 8'h4E);
		send_byte(8'h43, 1'b0);
		send_byte(nmeatr_pkg::CH_STAR, 1'b1);
		wait_drained();
		apply_settings(1'b1, 1'b1, 8'h47, 8'h50, 8'h47, 8'h4E);
		send_byte(8'h44, 1'b0);
		send_byte(nmeatr_pkg::CH_STAR, 1'b0);
		send_byte(8'h71, 1'b0);
		send_byte(8'h71, 1'b1);

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				0: apply_settings(1'b1, 1'b1, 8'h47, 8'h50, 8'h00, 8'hFF);
				1: apply_settings(1'b1, 1'b0, 8'h47, 8'h50, 8'h49, 8'h4E);
				2: apply_settings(1'b1, 1'b0, 8'hFF, 8'h01, 8'hFF, 8'h00);
				default: apply_settings(1'b1, 1'b1, 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
			endcase
			send_idle_pct  = idle_tbl[p];
			recv_stall_pct = stall_tbl[p];
			// long body runs past the length limit
			if (long_tbl[p] != 0)
				send_sentence(long_tbl[p], 1'b1);
			goal   = sent + 10;
			paused = 1'b0;
			while (sent < goal) begin
				if (!paused && sent >= goal - 5) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_sentence($urandom_range(20), $urandom_range(9) < 7);
				end else if (pick < 85) begin
					// broken sentence: no star, runs into whatever follows
					send_byte(nmeatr_pkg::CH_DOLLAR, 1'b0);
					n = $urandom_range(6);
					for (int k = 0; k < n; k++)
						send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
				end else begin
					n = $urandom_range(6, 1);
					for (int k = 0; k < n; k++)
						send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
				end
			end
		end

		wait_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
